// File: hw/rtl/eafd_pkg.sv
// ============================================================================
// eafd_pkg
// Shared types and constants for the escaped frame deframer.
// ============================================================================
package eafd_pkg;

    // Link-level byte codes
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] ESC_XOR    = 8'h20;
    localparam logic [7:0] START_BYTE = 8'h7E;
    localparam logic [7:0] SUM_BASE   = 8'hFF;

    // Number of header bytes folded into the checksum and discarded
    localparam logic [15:0] HEADER_LEN = 16'd5;

    // Reset value of the length limit register
    localparam logic [15:0] MAX_LEN_RESET = 16'd256;

    // Register index decoded from paddr[2]
    localparam logic REG_MAX_FRAME_LENGTH = 1'b0;

    // Byte queue between the front and back ends
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Receive sequencer states
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_LEN_HI = 3'd1,
        MODE_LEN_LO = 3'd2,
        MODE_HEADER = 3'd3,
        MODE_BODY   = 3'd4
    } rx_mode_t;

    // Result event codes
    typedef enum logic [1:0] {
        EV_PAYLOAD      = 2'd0,
        EV_FRAME_OK     = 2'd1,
        EV_CHECKSUM_BAD = 2'd2,
        EV_TOO_LONG     = 2'd3
    } event_t;

    // Queue status seen by the two ends
    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

// File: hw/rtl/escaped_api_frame_deframer_unit.sv
// ============================================================================
// escaped_api_frame_deframer_unit
// A byte that causes a result passes through the byte queue and then the
// result register before it shows on the master side. Throughput: one byte
// per cycle while the queue is not full and the master drains results.
// Reset: synchronous, active low; clears the escape
// flag, queue, sequencer and result valid, and sets the length limit to 256.
// ============================================================================
module escaped_api_frame_deframer_unit import eafd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    // Raw byte stream from the serial link.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

    // Deframed result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] data, [23:8] byte_count
    output logic [1:0]  m_axis_tuser,   // [1:0] event_res

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // The front end strips escapes and pushes each unescaped byte into a
    // short queue. The back end pops a byte whenever its result register is
    // free or being drained, so either side may stall without stopping the
    // other until the queue fills.

    queue_status_t q_status;
    logic          push;
    logic [7:0]    push_byte;
    logic          pop;
    logic [7:0]    q_byte;
    logic [15:0]   max_frame_length_reg;
    logic [15:0]   max_frame_length_next;
    logic          cfg_write;
    logic [7:0]    res_data;
    logic [15:0]   res_count;

    // Register writes complete in the access phase; reads are decoded on
    // the register index held in paddr[2].
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        max_frame_length_next = max_frame_length_reg;
        if (cfg_write && (paddr[2] == REG_MAX_FRAME_LENGTH)) begin
            max_frame_length_next = pwdata[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_frame_length_reg <= MAX_LEN_RESET;
        end else begin
            max_frame_length_reg <= max_frame_length_next;
        end
    end

    assign prdata = (paddr[2] == REG_MAX_FRAME_LENGTH) ?
                    {16'h0000, max_frame_length_reg} : 32'h0000_0000;

    eafd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .q_status  (q_status),
        .push      (push),
        .push_byte (push_byte)
    );

    eafd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_byte (push_byte),
        .pop       (pop),
        .pop_byte  (q_byte),
        .status    (q_status)
    );

    // The back end owns the frame state and the result register.
    eafd_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_status         (q_status),
        .q_byte           (q_byte),
        .pop              (pop),
        .max_frame_length (max_frame_length_reg),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_event        (m_axis_tuser),
        .out_data         (res_data),
        .out_count        (res_count)
    );

    assign m_axis_tdata = {res_count, res_data};

endmodule

// File: hw/rtl/eafd_front.sv
// ============================================================================
// eafd_front
// Accepts raw bytes, strips escape codes and pushes unescaped bytes.
// ============================================================================
module eafd_front import eafd_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  queue_status_t q_status,
    output logic          push,
    output logic [7:0]    push_byte
);

    logic escape_pending_reg;
    logic escape_pending_next;
    logic accept;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        escape_pending_next = escape_pending_reg;
        push                = 1'b0;
        push_byte           = in_byte;
        if (accept) begin
            if (in_byte == ESC_BYTE) begin
                // A repeated escape keeps the escape pending.
                escape_pending_next = 1'b1;
            end else begin
                push                = 1'b1;
                push_byte           = escape_pending_reg ? (in_byte ^ ESC_XOR) : in_byte;
                escape_pending_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escape_pending_reg <= 1'b0;
        end else begin
            escape_pending_reg <= escape_pending_next;
        end
    end

endmodule

// File: hw/rtl/eafd_queue.sv
// ============================================================================
// eafd_queue
// Short byte FIFO decoupling the unescape front end from the sequencer.
// ============================================================================
module eafd_queue import eafd_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  logic [7:0]    push_byte,
    input  logic          pop,
    output logic [7:0]    pop_byte,
    output queue_status_t status
);

    logic [7:0]          entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_byte     = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hw/rtl/eafd_back.sv
// ============================================================================
// eafd_back
// Frame sequencer: length, header, payload and checksum, with result register.
// ============================================================================
module eafd_back import eafd_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  queue_status_t q_status,
    input  logic [7:0]    q_byte,
    output logic          pop,
    input  logic [15:0]   max_frame_length,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    out_event,
    output logic [7:0]    out_data,
    output logic [15:0]   out_count
);

    rx_mode_t    mode_reg;
    rx_mode_t    mode_next;
    logic [15:0] frame_length_reg;
    logic [15:0] frame_length_next;
    logic [15:0] byte_index_reg;
    logic [15:0] byte_index_next;
    logic [7:0]  running_sum_reg;
    logic [7:0]  running_sum_next;
    logic [15:0] payload_count_reg;
    logic [15:0] payload_count_next;

    logic        res_valid;
    event_t      res_event;
    logic [7:0]  res_data;
    logic [15:0] res_count;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  out_event_reg;
    logic [7:0]  out_data_reg;
    logic [15:0] out_count_reg;

    logic [15:0] length_full;
    logic [15:0] header_index;
    logic        in_payload;

    // The result register takes a new result while the old one is drained.
    assign pop          = !q_status.empty && (!out_valid_reg || out_ready);
    assign length_full  = {frame_length_reg[15:8], q_byte};
    assign header_index = byte_index_reg + 16'd1;
    assign in_payload   = byte_index_reg < frame_length_reg;

    // Next state
    always_comb begin
        mode_next = mode_reg;
        if (pop) begin
            unique case (mode_reg)
                MODE_IDLE: begin
                    if (q_byte == START_BYTE) begin
                        mode_next = MODE_LEN_HI;
                    end
                end
                MODE_LEN_HI: begin
                    mode_next = MODE_LEN_LO;
                end
                MODE_LEN_LO: begin
                    mode_next = (length_full > max_frame_length) ? MODE_IDLE : MODE_HEADER;
                end
                MODE_HEADER: begin
                    if (header_index >= HEADER_LEN) begin
                        mode_next = MODE_BODY;
                    end
                end
                MODE_BODY: begin
                    if (!in_payload) begin
                        mode_next = MODE_IDLE;
                    end
                end
                default: begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end
    end

    // Datapath and results
    always_comb begin
        frame_length_next  = frame_length_reg;
        byte_index_next    = byte_index_reg;
        running_sum_next   = running_sum_reg;
        payload_count_next = payload_count_reg;
        res_valid          = 1'b0;
        res_event          = EV_PAYLOAD;
        res_data           = q_byte;
        res_count          = payload_count_reg;
        if (pop) begin
            unique case (mode_reg)
                MODE_IDLE: begin
                    if (q_byte == START_BYTE) begin
                        frame_length_next  = '0;
                        byte_index_next    = '0;
                        running_sum_next   = '0;
                        payload_count_next = '0;
                    end
                end
                MODE_LEN_HI: begin
                    frame_length_next = {q_byte, 8'h00};
                end
                MODE_LEN_LO: begin
                    frame_length_next = length_full;
                    if (length_full > max_frame_length) begin
                        res_valid = 1'b1;
                        res_event = EV_TOO_LONG;
                        res_data  = '0;
                        res_count = '0;
                    end
                end
                MODE_HEADER: begin
                    running_sum_next = running_sum_reg + q_byte;
                    byte_index_next  = header_index;
                end
                MODE_BODY: begin
                    res_valid = 1'b1;
                    if (in_payload) begin
                        running_sum_next   = running_sum_reg + q_byte;
                        byte_index_next    = header_index;
                        payload_count_next = payload_count_reg + 16'd1;
                        res_event          = EV_PAYLOAD;
                        res_count          = payload_count_next;
                    end else begin
                        res_event = ((SUM_BASE - running_sum_reg) == q_byte) ?
                                    EV_FRAME_OK : EV_CHECKSUM_BAD;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (pop && res_valid) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= MODE_IDLE;
            frame_length_reg  <= '0;
            byte_index_reg    <= '0;
            running_sum_reg   <= '0;
            payload_count_reg <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            mode_reg          <= mode_next;
            frame_length_reg  <= frame_length_next;
            byte_index_reg    <= byte_index_next;
            running_sum_reg   <= running_sum_next;
            payload_count_reg <= payload_count_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && res_valid) begin
            out_event_reg <= res_event;
            out_data_reg  <= res_data;
            out_count_reg <= res_count;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_event = out_event_reg;
    assign out_data  = out_data_reg;
    assign out_count = out_count_reg;

endmodule

// File: sim/deframe_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// deframe_checker
// Watches the byte, result and register channels of the escaped frame
// deframer, predicts every result from the accepted bytes and compares the
// results that come out against those predictions in order.
// ============================================================================
module deframe_checker import eafd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        event_t      ev;
        logic [7:0]  data;
        logic [15:0] count;
    } deframe_res_t;

    // Predicted copy of the block's state and its length limit.
    logic        esc_armed;
    rx_mode_t    mode;
    logic [15:0] len_field;
    logic [15:0] hdr_idx;
    logic [7:0]  run_sum;
    logic [15:0] pay_cnt;
    logic [15:0] len_limit;

    deframe_res_t expected_results[$];
    int           mismatch_count = 0;
    int           waiting_count  = 0;

    assign errors  = mismatch_count;
    assign pending = waiting_count;

    // Advances the predicted state by one received byte; got is set when the
    // byte produces a result.
    function automatic void deframe_byte(input logic [7:0] raw, output bit got,
                                         output deframe_res_t res);
        logic [7:0] b;
        logic [7:0] want;
        b   = raw;
        got = 1'b0;
        res = '0;
        if (raw == ESC_BYTE) begin
            esc_armed = 1'b1;
            return;
        end
        if (esc_armed) begin
            b = raw ^ ESC_XOR;
            esc_armed = 1'b0;
        end
        case (mode)
            MODE_IDLE: begin
                if (b == START_BYTE) begin
                    mode      = MODE_LEN_HI;
                    len_field = '0;
                    hdr_idx   = '0;
                    run_sum   = '0;
                    pay_cnt   = '0;
                end
            end
            MODE_LEN_HI: begin
                len_field = {b, 8'h00};
                mode      = MODE_LEN_LO;
            end
            MODE_LEN_LO: begin
                len_field = len_field | {8'h00, b};
                if (len_field > len_limit) begin
                    mode = MODE_IDLE;
                    got  = 1'b1;
                    res  = '{ev: EV_TOO_LONG, data: 8'h00, count: 16'h0000};
                end else begin
                    mode = MODE_HEADER;
                end
            end
            MODE_HEADER: begin
                run_sum = run_sum + b;
                hdr_idx = hdr_idx + 16'd1;
                if (hdr_idx >= HEADER_LEN) mode = MODE_BODY;
            end
            MODE_BODY: begin
                got = 1'b1;
                if (hdr_idx < len_field) begin
                    run_sum = run_sum + b;
                    hdr_idx = hdr_idx + 16'd1;
                    pay_cnt = pay_cnt + 16'd1;
                    res = '{ev: EV_PAYLOAD, data: b, count: pay_cnt};
                end else begin
                    want = SUM_BASE - run_sum;
                    mode = MODE_IDLE;
                    res  = '{ev: (want == b) ? EV_FRAME_OK : EV_CHECKSUM_BAD,
                             data: b, count: pay_cnt};
                end
            end
            default: mode = MODE_IDLE;
        endcase
    endfunction

    always @(posedge aclk) begin
        deframe_res_t want_res;
        deframe_res_t seen_res;
        bit           got;
        if (!aresetn) begin
            esc_armed = 1'b0;
            mode      = MODE_IDLE;
            len_field = '0;
            hdr_idx   = '0;
            run_sum   = '0;
            pay_cnt   = '0;
            len_limit = MAX_LEN_RESET;
            expected_results.delete();
        end else begin
            // Results first: a byte accepted at this edge cannot show up yet.
            if (m_axis_tvalid && m_axis_tready) begin
                seen_res = '{ev: event_t'(m_axis_tuser), data: m_axis_tdata[7:0],
                             count: m_axis_tdata[23:8]};
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected result ev=%0d data=%02h count=%0d",
                                 $realtime, seen_res.ev, seen_res.data, seen_res.count);
                end else begin
                    want_res = expected_results.pop_front();
                    if (seen_res.ev !== want_res.ev || seen_res.data !== want_res.data ||
                        seen_res.count !== want_res.count) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: mismatch expected ev=%0d data=%02h count=%0d,",
                                      " got ev=%0d data=%02h count=%0d"}, $realtime,
                                     want_res.ev, want_res.data, want_res.count,
                                     seen_res.ev, seen_res.data, seen_res.count);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                deframe_byte(s_axis_tdata, got, want_res);
                if (got) expected_results.push_back(want_res);
            end
            if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_FRAME_LENGTH)
                len_limit = pwdata[15:0];
        end
        waiting_count = expected_results.size();
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Drives escaped serial bytes into the frame deframer: a short directed
// opening, then mostly well-formed frames with random content, truncated
// frames and noise, under several length limits and idling patterns.
// ============================================================================
module tb import eafd_pkg::*;;

    // Generous bound on the whole run, far above the slowest legal run.
    localparam int RUN_LIMIT_NS = 5_000_000;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = 3'd0;
    logic [31:0] pwdata        = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;

    // Stimulus bookkeeping shared by the sender and the receiver.
    int items_sent    = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int idle_mode     = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int lim_now       = MAX_LEN_RESET;

    // The opening bytes, as three frames:
    // a start byte reached through a repeated escape, with a length below
    // five, so the header is followed directly by a good checksum;
    // a length one above the reset limit, which ends the frame at once;
    // a frame whose header is all ones and whose payload carries a start
    // byte as plain data and a zero, closed with a wrong checksum.
    logic [7:0] opening_bytes [25] = '{
        8'h7D, 8'h7D, 8'h5E, 8'h00, 8'h03, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'hF0,
        8'h7E, 8'h01, 8'h01,
        8'h7E, 8'h00, 8'h07, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7E, 8'h00, 8'h85
    };

    always #10 aclk = ~aclk;

    escaped_api_frame_deframer_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    deframe_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .errors        (errors),
        .pending       (pending)
    );

    // The receiver changes its ready at the falling edge. In the last phase
    // it first holds off for a long stretch while the sender keeps offering
    // payload bytes, so the byte queue fills and the input side stalls.
    always @(negedge aclk) begin
        if (idle_mode == 2 && !hold_done) begin
            hold_left = 200;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Offers one byte, after a random number of idle cycles, and returns at
    // the falling edge after the request is taken. When no idle cycle is
    // drawn, valid simply stays high into the next request.
    task automatic put_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge aclk); while (!s_axis_tready);
        items_sent++;
        @(negedge aclk);
    endtask

    // Sends one frame byte with link escaping. An escape byte must always be
    // escaped; other bytes are escaped now and then, sometimes with a
    // repeated escape in front. A byte whose escaped form would itself be the
    // escape code is always sent plain.
    task automatic put_coded(input logic [7:0] b);
        if (b == ESC_BYTE ||
            ((b ^ ESC_XOR) != ESC_BYTE && $urandom_range(0, 15) == 0)) begin
            if ($urandom_range(0, 7) == 0) put_byte(ESC_BYTE);
            put_byte(ESC_BYTE);
            put_byte(b ^ ESC_XOR);
        end else begin
            put_byte(b);
        end
    endtask

    // Builds one frame against the current limit: usually a short accepted
    // frame with a good checksum, sometimes a bad checksum, a length over the
    // limit, or a frame cut off partway.
    task automatic send_frame();
        logic [7:0] frame_q[$];
        logic [7:0] ck;
        logic [7:0] b;
        int         flen;
        int         cap;
        int         npay;
        frame_q.delete();
        if (lim_now < 65535 && $urandom_range(0, 9) == 0) begin
            // Over the limit: the block stops after the length field.
            flen = $urandom_range(0, 1) ? lim_now + 1 : $urandom_range(lim_now + 1, 65535);
            frame_q = '{START_BYTE, flen[15:8], flen[7:0]};
        end else begin
            cap = (lim_now < 40) ? lim_now : 40;
            if ($urandom_range(0, 19) == 0) cap = (lim_now < 300) ? lim_now : 300;
            flen = $urandom_range(0, cap);
            npay = (flen > 5) ? flen - 5 : 0;
            frame_q = '{START_BYTE, flen[15:8], flen[7:0]};
            ck = 8'h00;
            for (int i = 0; i < 5 + npay; i++) begin
                b  = $urandom_range(0, 255);
                ck = ck + b;
                frame_q.push_back(b);
            end
            ck = SUM_BASE - ck;
            if ($urandom_range(0, 6) == 0) ck = ck ^ 8'($urandom_range(1, 255));
            frame_q.push_back(ck);
            // A broken frame: the tail is lost and the next frame's bytes are
            // taken as the rest of this one.
            if ($urandom_range(0, 9) == 0)
                frame_q = frame_q[0:$urandom_range(0, frame_q.size() - 2)];
        end
        foreach (frame_q[i]) begin
            if (i == 0 && $urandom_range(0, 3) != 0) put_byte(frame_q[i]);
            else put_coded(frame_q[i]);
        end
    endtask

    // Random traffic until the running byte count reaches goal: mostly
    // frames, the rest short bursts of raw noise between them.
    task automatic run_traffic(input int goal);
        int n;
        while (items_sent < goal) begin
            if ($urandom_range(0, 99) < 85) begin
                send_frame();
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) put_byte($urandom_range(0, 255));
            end
        end
    endtask

    // Waits until every predicted result has come out, then waits on a little
    // for bytes that cause no result but may still sit in the queue.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        for (int k = 0; k < 5000 && pending != 0; k++) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // Setup cycle, then access cycle; the write lands at the edge where the
    // access cycle meets pready.
    task automatic write_limit(input logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MAX_FRAME_LENGTH, 2'b00};
        pwdata  <= {16'h0000, v};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        lim_now = v;
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Phase one: reset limit, sender idles less than the receiver.
        idle_mode     = 0;
        src_idle_pct  = 38;
        sink_idle_pct = 64;
        foreach (opening_bytes[i]) put_byte(opening_bytes[i]);
        run_traffic(525);
        settle();

        // Phase two: the roles swap, and the limit goes to both extremes.
        idle_mode     = 1;
        src_idle_pct  = 64;
        sink_idle_pct = 38;
        write_limit(16'h0000);
        run_traffic(775);
        settle();
        write_limit(16'hFFFF);
        run_traffic(1025);
        settle();

        // Phase three: a mid-range limit, no idling, and the long hold-off.
        write_limit(16'($urandom_range(6, 80)));
        idle_mode     = 2;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_traffic(1525);
        settle();

        if (errors == 0 && pending == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("tb: errors");
        $finish;
    end

endmodule
